@@ design/sgeb_pkg.sv @@
// ----------------------------------------------------------------------------
// sgeb_pkg
// Shared types and constants of the separable Gaussian edge blur.
// ----------------------------------------------------------------------------
`default_nettype none

package sgeb_pkg;

    localparam int TAP_COUNT  = 17;
    localparam int HALF_TAPS  = 8;
    localparam int SUM_W      = 18;
    localparam int WEIGHT_W   = 7;

    // s/748 == (s>>2)/187; reciprocal rounded up, exact for all 16-bit dividends
    localparam logic [16:0] DIV_RECIP = 17'd89718;
    localparam int          DIV_SHIFT = 24;

    localparam logic [WEIGHT_W-1:0] GAUSS_TAPS [TAP_COUNT] = '{
        7'd9, 7'd15, 7'd24, 7'd34, 7'd46, 7'd59, 7'd70, 7'd77, 7'd80,
        7'd77, 7'd70, 7'd59, 7'd46, 7'd34, 7'd24, 7'd15, 7'd9
    };

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_BLUR  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_RADIUS = 2'd2,
        REG_FORMAT = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_PIX,
        ST_COPY,
        ST_TAP,
        ST_DRAIN,
        ST_DIV,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic       clear;
        logic       acc;
        logic [1:0] lane;
    } mac_ctrl_t;

endpackage

`default_nettype wire

@@ design/sgeb_ram.sv @@
// ----------------------------------------------------------------------------
// sgeb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sgeb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ design/sgeb_mac.sv @@
// ----------------------------------------------------------------------------
// sgeb_mac
// Four-lane weighted accumulator with a shared divide-by-kernel-sum unit.
// ----------------------------------------------------------------------------
`default_nettype none

module sgeb_mac (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire sgeb_pkg::mac_ctrl_t             ctrl,
    input  wire logic [31:0]                     pixel,
    input  wire logic [sgeb_pkg::WEIGHT_W-1:0]   weight,
    output logic      [7:0]                      quotient
);

    logic [sgeb_pkg::SUM_W-1:0] sum_reg  [4];
    logic [sgeb_pkg::SUM_W-1:0] sum_next [4];
    logic [15:0]                div_in;
    logic [32:0]                div_prod;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (ctrl.clear) begin
                sum_next[k] = '0;
            end else if (ctrl.acc) begin
                sum_next[k] = sum_reg[k] + sgeb_pkg::SUM_W'(pixel[8*k +: 8])
                                         * sgeb_pkg::SUM_W'(weight);
            end else begin
                sum_next[k] = sum_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 4; k++) sum_reg[k] <= '0;
        end else begin
            for (int k = 0; k < 4; k++) sum_reg[k] <= sum_next[k];
        end
    end

    assign div_in   = sum_reg[ctrl.lane][sgeb_pkg::SUM_W-1:2];
    assign div_prod = 33'(div_in) * 33'(sgeb_pkg::DIV_RECIP);
    assign quotient = div_prod[sgeb_pkg::DIV_SHIFT +: 8];

endmodule

`default_nettype wire

@@ design/separable_gaussian_edge_blur.sv @@
// ----------------------------------------------------------------------------
// separable_gaussian_edge_blur
// Frame store with a two-pass 17-tap Gaussian blur over its edge band.
// ----------------------------------------------------------------------------
// Usage:
//  s_ beats carry a command in s_tuser (write, blur, read, no-op) with column,
//  row and pixel in s_tdata. Every accepted beat returns exactly one m_ beat:
//  m_tdata holds the pixel read (zero otherwise), m_tuser the skip flag.
//  cfg_ writes set width, height, radius and format; cfg_ready is always high.
//  Writes and no-ops answer from the registered output; reads pass ST_READ first.
//  A blur walks the frame twice through one accumulator: a copied pixel passes
//  ST_PIX and ST_COPY, a filtered pixel ST_PIX, 17 tap reads, a drain, 4 divides
//  and a write; s_tready is low meanwhile. Tap reads come from the single read
//  port of each frame RAM.
//  Reset clears the sequencer and restores the configuration defaults; the
//  pixel RAMs are not cleared. While m_tvalid waits on m_tready no new beat
//  is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module separable_gaussian_edge_blur #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // column[5:0], row[11:6], pixel_in[43:12], zero pad
    input  wire logic [1:0]  s_tuser,   // command[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // pixel_out[31:0]
    output logic             m_tuser,   // status[0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [9:0]  cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 1);
    localparam int PW    = (CW > RW) ? CW : RW;
    localparam int SW    = PW + 5;
    localparam int BW    = ((PW + 5 > 10) ? PW + 5 : 10) + 1;

    // configuration
    logic [6:0] width_reg, height_reg;
    logic [9:0] radius_reg;
    logic       format_reg;

    // sequencer
    sgeb_pkg::state_t state_reg, state_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [4:0]    tap_reg, tap_next;
    logic          vpass_reg, vpass_next;
    logic [1:0]    lane_reg, lane_next;
    logic          pend_reg, pend_next;
    logic [sgeb_pkg::WEIGHT_W-1:0] pend_w_reg, pend_w_next;
    logic [31:0]   result_reg, result_next;
    logic          rd_ok_reg, rd_ok_next;

    // output
    logic          m_valid_reg, m_valid_next;
    logic [31:0]   m_data_reg, m_data_next;
    logic          m_user_reg, m_user_next;

    // datapath
    logic [CW-1:0] w_eff;
    logic [RW-1:0] h_eff;
    logic [PW-1:0] pos, span;
    logic [SW-1:0] tap_sum, src;
    logic          tap_ok, copy_pix, last_col, last_row;
    logic [BW-1:0] p16, r_ext, n16;
    logic          s_acc, in_store;
    logic [5:0]    in_col, in_row;
    logic [31:0]   in_pix;
    logic [AW-1:0] here_addr, tap_addr, host_addr;
    logic [31:0]   frame_rdata, temp_rdata, src_rdata;
    logic          frame_we, temp_we;
    logic [AW-1:0] frame_waddr, frame_raddr;
    logic [31:0]   frame_wdata, dst_wdata;
    logic [7:0]    quotient;
    sgeb_pkg::mac_ctrl_t mac_ctrl;

    function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
        addr_of = AW'(r * MAX_WIDTH + c);
    endfunction

    assign in_col   = s_tdata[5:0];
    assign in_row   = s_tdata[11:6];
    assign in_pix   = s_tdata[43:12];
    assign s_acc    = s_tvalid && s_tready;
    assign in_store = (32'(in_col) < MAX_WIDTH) && (32'(in_row) < MAX_HEIGHT);
    assign host_addr = AW'(32'(in_row) * MAX_WIDTH + 32'(in_col));

    assign w_eff = (32'(width_reg) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(width_reg);
    assign h_eff = (32'(height_reg) > MAX_HEIGHT) ? RW'(MAX_HEIGHT) : RW'(height_reg);
    assign pos   = vpass_reg ? PW'(row_reg) : PW'(col_reg);
    assign span  = vpass_reg ? PW'(h_eff) : PW'(w_eff);

    assign tap_sum = SW'(pos) + SW'(tap_reg);
    assign src     = tap_sum - SW'(sgeb_pkg::HALF_TAPS);
    assign tap_ok  = (tap_sum >= SW'(sgeb_pkg::HALF_TAPS)) && (src < SW'(span));

    assign p16   = BW'(pos) << 4;
    assign n16   = BW'(span) << 4;
    assign r_ext = BW'(radius_reg);
    assign copy_pix = (vpass_reg ? (r_ext <= p16) : (r_ext < p16)) && (p16 + r_ext < n16);

    assign last_col  = (col_reg + CW'(1)) == w_eff;
    assign last_row  = (row_reg + RW'(1)) == h_eff;
    assign here_addr = addr_of(row_reg, col_reg);
    assign tap_addr  = vpass_reg ? addr_of(RW'(src), col_reg) : addr_of(row_reg, CW'(src));
    assign src_rdata = vpass_reg ? temp_rdata : frame_rdata;
    assign dst_wdata = (state_reg == sgeb_pkg::ST_COPY) ? src_rdata : result_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sgeb_pkg::ST_IDLE: begin
                if (s_acc && sgeb_pkg::cmd_t'(s_tuser) == sgeb_pkg::CMD_READ) begin
                    state_next = sgeb_pkg::ST_READ;
                end else if (s_acc && sgeb_pkg::cmd_t'(s_tuser) == sgeb_pkg::CMD_BLUR
                             && format_reg && w_eff != '0 && h_eff != '0) begin
                    state_next = sgeb_pkg::ST_PIX;
                end
            end
            sgeb_pkg::ST_READ:  state_next = sgeb_pkg::ST_IDLE;
            sgeb_pkg::ST_PIX:   state_next = copy_pix ? sgeb_pkg::ST_COPY : sgeb_pkg::ST_TAP;
            sgeb_pkg::ST_TAP: begin
                if (tap_reg == 5'(sgeb_pkg::TAP_COUNT - 1)) state_next = sgeb_pkg::ST_DRAIN;
            end
            sgeb_pkg::ST_DRAIN: state_next = sgeb_pkg::ST_DIV;
            sgeb_pkg::ST_DIV: begin
                if (lane_reg == 2'd3) state_next = sgeb_pkg::ST_WRITE;
            end
            sgeb_pkg::ST_COPY, sgeb_pkg::ST_WRITE: begin
                state_next = (last_col && last_row && vpass_reg) ? sgeb_pkg::ST_IDLE
                                                                 : sgeb_pkg::ST_PIX;
            end
            default: state_next = sgeb_pkg::ST_IDLE;
        endcase
    end

    // datapath control and outputs
    always_comb begin
        col_next     = col_reg;
        row_next     = row_reg;
        tap_next     = tap_reg;
        vpass_next   = vpass_reg;
        lane_next    = lane_reg;
        pend_next    = 1'b0;
        pend_w_next  = pend_w_reg;
        result_next  = result_reg;
        rd_ok_next   = rd_ok_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        mac_ctrl     = '{clear: 1'b0, acc: pend_reg, lane: lane_reg};
        frame_we     = 1'b0;
        temp_we      = 1'b0;
        frame_waddr  = here_addr;
        frame_wdata  = dst_wdata;
        frame_raddr  = tap_addr;
        s_tready     = (state_reg == sgeb_pkg::ST_IDLE) && (!m_valid_reg || m_tready);

        unique case (state_reg)
            sgeb_pkg::ST_IDLE: begin
                frame_waddr = host_addr;
                frame_wdata = in_pix;
                frame_raddr = host_addr;
                if (s_acc) begin
                    m_data_next = '0;
                    m_user_next = 1'b0;
                    rd_ok_next  = in_store;
                    vpass_next  = 1'b0;
                    col_next    = '0;
                    row_next    = '0;
                    unique case (sgeb_pkg::cmd_t'(s_tuser))
                        sgeb_pkg::CMD_WRITE: begin
                            frame_we     = in_store;
                            m_valid_next = 1'b1;
                        end
                        sgeb_pkg::CMD_BLUR: begin
                            m_user_next  = !format_reg;
                            m_valid_next = !format_reg || w_eff == '0 || h_eff == '0;
                        end
                        sgeb_pkg::CMD_READ: ;
                        default: m_valid_next = 1'b1;
                    endcase
                end
            end
            sgeb_pkg::ST_READ: begin
                m_valid_next = 1'b1;
                m_data_next  = rd_ok_reg ? frame_rdata : '0;
            end
            sgeb_pkg::ST_PIX: begin
                frame_raddr    = here_addr;
                mac_ctrl.clear = 1'b1;
                tap_next       = '0;
            end
            sgeb_pkg::ST_TAP: begin
                pend_next   = tap_ok;
                pend_w_next = sgeb_pkg::GAUSS_TAPS[tap_reg];
                tap_next    = tap_reg + 5'd1;
                lane_next   = '0;
            end
            sgeb_pkg::ST_DRAIN: lane_next = '0;
            sgeb_pkg::ST_DIV: begin
                result_next[8*lane_reg +: 8] = quotient;
                lane_next = lane_reg + 2'd1;
            end
            sgeb_pkg::ST_COPY, sgeb_pkg::ST_WRITE: begin
                frame_we = vpass_reg;
                temp_we  = !vpass_reg;
                if (!last_col) begin
                    col_next = col_reg + CW'(1);
                end else begin
                    col_next = '0;
                    if (!last_row) begin
                        row_next = row_reg + RW'(1);
                    end else begin
                        row_next = '0;
                        if (vpass_reg) begin
                            m_valid_next = 1'b1;
                        end
                        vpass_next = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sgeb_pkg::ST_IDLE;
            col_reg     <= '0;
            row_reg     <= '0;
            tap_reg     <= '0;
            vpass_reg   <= 1'b0;
            lane_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            width_reg   <= 7'd64;
            height_reg  <= 7'd64;
            radius_reg  <= '0;
            format_reg  <= 1'b1;
        end else begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            tap_reg     <= tap_next;
            vpass_reg   <= vpass_next;
            lane_reg    <= lane_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                unique case (sgeb_pkg::reg_idx_t'(cfg_index))
                    sgeb_pkg::REG_WIDTH:  width_reg  <= cfg_data[6:0];
                    sgeb_pkg::REG_HEIGHT: height_reg <= cfg_data[6:0];
                    sgeb_pkg::REG_RADIUS: radius_reg <= cfg_data;
                    sgeb_pkg::REG_FORMAT: format_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_w_reg <= pend_w_next;
        result_reg <= result_next;
        rd_ok_reg  <= rd_ok_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    sgeb_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_frame_ram (
        .aclk  (aclk),
        .we    (frame_we),
        .waddr (frame_waddr),
        .wdata (frame_wdata),
        .raddr (frame_raddr),
        .rdata (frame_rdata)
    );

    sgeb_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_temp_ram (
        .aclk  (aclk),
        .we    (temp_we),
        .waddr (here_addr),
        .wdata (dst_wdata),
        .raddr ((state_reg == sgeb_pkg::ST_PIX) ? here_addr : tap_addr),
        .rdata (temp_rdata)
    );

    sgeb_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (mac_ctrl),
        .pixel    (src_rdata),
        .weight   (pend_w_reg),
        .quotient (quotient)
    );

endmodule

`default_nettype wire
